[hw/rtl/multiplexed_seven_segment_scanner_core_defines.svh]
// Assertion macros for the seven-segment scanner.
// Included by the top level; the bodies drop out when SYNTHESIS is defined.
`ifndef MULTIPLEXED_SEVEN_SEGMENT_SCANNER_CORE_DEFINES_SVH
`define MULTIPLEXED_SEVEN_SEGMENT_SCANNER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define MSSS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Scanner check failed.");
`define MSSS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Scanner check failed.");
`else
`define MSSS_ASSERT_IMP(label, clk, rst, ante, cons)
`define MSSS_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

[hw/rtl/msss_pkg.sv]
// Package for the seven-segment scanner: request actions, code constants,
// and the decimal code table. No dependencies.
package msss_pkg;

   localparam int NUM_DIGITS_DEFAULT     = 6;
   localparam int COLON_POSITION_DEFAULT = 4;

   localparam logic [7:0]  CATHODE_BIT      = 8'h80;
   localparam logic [7:0]  COLON_CODE       = 8'b0110_0000;
   localparam logic [15:0] SCAN_INTERVAL_RST = 16'd1000;
   localparam logic [16:0] ELAPSED_MAX      = 17'h1FFFF;

   typedef enum logic [2:0] {
      ACT_TICK    = 3'd0,
      ACT_DECIMAL = 3'd1,
      ACT_RAW     = 3'd2,
      ACT_CLEAR   = 3'd3,
      ACT_COLON   = 3'd4
   } action_type;

   // Segment code of (value mod 10); the quotient comes from a reciprocal multiply.
   function automatic logic [7:0] decimal_code(input logic [7:0] value);
      logic [15:0] prod;
      logic [7:0]  quo;
      logic [7:0]  diff;
      logic [7:0]  code;
      prod = 16'(value) * 16'd205;
      quo  = {3'b000, prod[15:11]};
      diff = value - 8'(quo * 8'd10);
      unique case (diff[3:0])
         4'd0:    code = 8'b0111_1110;
         4'd1:    code = 8'b0001_1000;
         4'd2:    code = 8'b0011_0111;
         4'd3:    code = 8'b0011_1101;
         4'd4:    code = 8'b0101_1001;
         4'd5:    code = 8'b0110_1101;
         4'd6:    code = 8'b0110_1111;
         4'd7:    code = 8'b0011_1000;
         4'd8:    code = 8'b0111_1111;
         4'd9:    code = 8'b0111_1101;
         default: code = 8'h00;
      endcase
      return code;
   endfunction

endpackage

[hw/rtl/multiplexed_seven_segment_scanner_core.sv]
// Multiplexed seven-segment scanner core, top level.
// Depends on msss_pkg and multiplexed_seven_segment_scanner_core_defines.svh.
//
// The core takes one request per clock cycle while req_stall is low. A request
// is held in an input register and is applied from there to the digit codes
// and tick counter; a refresh result is then held in the result register.
// A tick refreshes one digit once the tick count since the last refresh
// exceeds scan_interval. While a result waits in the result register under
// rsp_stall, the request held in the input register cannot be applied and
// req_stall rises. The scan interval is written through the csr port, which
// is always ready.
`include "multiplexed_seven_segment_scanner_core_defines.svh"

module multiplexed_seven_segment_scanner_core #(
   parameter int NUM_DIGITS     = msss_pkg::NUM_DIGITS_DEFAULT,
   parameter int COLON_POSITION = msss_pkg::COLON_POSITION_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [2:0]  req_digit_pos,
   input  logic [7:0]  req_value,
   input  logic        req_colon_off,
   input  logic        req_blink_phase,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_digit_index,
   output logic        rsp_digit_enable,
   output logic        rsp_digit_level,
   output logic [6:0]  rsp_segment_levels,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_scan_interval
);

   localparam int         IDX_W     = $clog2(NUM_DIGITS);
   localparam logic [3:0] NUM_DIG_4 = 4'(NUM_DIGITS);
   localparam logic [IDX_W-1:0] COLON_SEL = IDX_W'(COLON_POSITION % NUM_DIGITS);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(NUM_DIGITS - 1);

   function automatic logic [3:0] reduce_pos(input logic [2:0] pos);
      logic [3:0] r;
      r = {1'b0, pos};
      for (int i = 0; i < 4; i++) begin
         if (r >= NUM_DIG_4) begin
            r = r - NUM_DIG_4;
         end
      end
      return r;
   endfunction

   logic                   s1_valid_ff, s1_valid_in;
   msss_pkg::action_type   s1_action_ff;
   logic [2:0]             s1_pos_ff;
   logic [7:0]             s1_value_ff;
   logic                   s1_colon_off_ff;
   logic                   s1_blink_ff;

   logic [7:0]             codes_ff [NUM_DIGITS];
   logic [IDX_W-1:0]       scan_ff, scan_in;
   logic [16:0]            elapsed_ff, elapsed_in;
   logic [15:0]            interval_ff;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [2:0]             rsp_index_ff;
   logic                   rsp_enable_ff;
   logic                   rsp_level_ff;
   logic [6:0]             rsp_segs_ff;

   logic                   proc_go;
   logic                   fire;
   logic [16:0]            elapsed_inc;
   logic [3:0]             pos_red;
   logic [IDX_W-1:0]       wr_idx;
   logic                   wr_en;
   logic [7:0]             wr_code;
   logic [7:0]             rd_code;
   logic                   lit;
   logic                   accept;

   assign accept    = req_valid && !req_stall;
   assign proc_go   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = s1_valid_ff && !proc_go;
   assign csr_ready = 1'b1;

   assign s1_valid_in = accept ? 1'b1 : (proc_go ? 1'b0 : s1_valid_ff);

   assign pos_red = reduce_pos(s1_pos_ff);

   always_comb begin
      wr_en   = 1'b0;
      wr_idx  = pos_red[IDX_W-1:0];
      wr_code = 8'h00;
      unique case (s1_action_ff)
         msss_pkg::ACT_DECIMAL: begin
            wr_en   = proc_go;
            wr_code = msss_pkg::decimal_code(s1_value_ff);
         end
         msss_pkg::ACT_RAW: begin
            wr_en   = proc_go;
            wr_code = s1_value_ff;
         end
         msss_pkg::ACT_CLEAR: begin
            wr_en = proc_go;
         end
         msss_pkg::ACT_COLON: begin
            wr_en  = proc_go;
            wr_idx = COLON_SEL;
            if (s1_blink_ff && !s1_colon_off_ff) begin
               wr_code = msss_pkg::COLON_CODE | msss_pkg::CATHODE_BIT;
            end
         end
         default: begin
            wr_en = 1'b0;
         end
      endcase
      if ((s1_action_ff == msss_pkg::ACT_DECIMAL || s1_action_ff == msss_pkg::ACT_RAW)
          && (pos_red == 4'd2 || pos_red == 4'd3)) begin
         wr_code = wr_code | msss_pkg::CATHODE_BIT;
      end
   end

   assign elapsed_inc = (elapsed_ff == msss_pkg::ELAPSED_MAX) ? elapsed_ff
                                                             : elapsed_ff + 17'd1;
   assign fire = proc_go && (s1_action_ff == msss_pkg::ACT_TICK)
                 && (elapsed_inc > {1'b0, interval_ff});

   always_comb begin
      elapsed_in = elapsed_ff;
      scan_in    = scan_ff;
      if (fire) begin
         elapsed_in = 17'd0;
         scan_in    = (scan_ff == LAST_IDX) ? '0 : scan_ff + 1'b1;
      end else if (proc_go && s1_action_ff == msss_pkg::ACT_TICK) begin
         elapsed_in = elapsed_inc;
      end
   end

   assign rd_code = codes_ff[scan_ff];
   assign lit     = (rd_code[6:0] != 7'd0);

   assign rsp_valid_in = fire ? 1'b1 : ((rsp_valid_ff && !rsp_stall) ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         scan_ff      <= '0;
         elapsed_ff   <= 17'd0;
         interval_ff  <= msss_pkg::SCAN_INTERVAL_RST;
         for (int i = 0; i < NUM_DIGITS; i++) begin
            codes_ff[i] <= 8'h00;
         end
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         scan_ff      <= scan_in;
         elapsed_ff   <= elapsed_in;
         if (csr_valid && csr_ready) begin
            interval_ff <= csr_scan_interval;
         end
         if (wr_en) begin
            codes_ff[wr_idx] <= wr_code;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_action_ff    <= msss_pkg::action_type'(req_action);
         s1_pos_ff       <= req_digit_pos;
         s1_value_ff     <= req_value;
         s1_colon_off_ff <= req_colon_off;
         s1_blink_ff     <= req_blink_phase;
      end
      if (fire) begin
         rsp_index_ff  <= 3'(scan_ff);
         rsp_enable_ff <= lit;
         rsp_level_ff  <= lit && rd_code[7];
         rsp_segs_ff   <= !lit ? 7'd0 : (rd_code[7] ? ~rd_code[6:0] : rd_code[6:0]);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_digit_index    = rsp_index_ff;
   assign rsp_digit_enable   = rsp_enable_ff;
   assign rsp_digit_level    = rsp_level_ff;
   assign rsp_segment_levels = rsp_segs_ff;

   `MSSS_ASSERT_IMP(a_blank_dark, clock, reset, rsp_valid && !rsp_digit_enable,
      !rsp_digit_level && rsp_segment_levels == 7'd0)
   `MSSS_ASSERT_IMP(a_index_range, clock, reset, rsp_valid,
      4'(rsp_digit_index) < 4'(NUM_DIGITS))
   `MSSS_ASSERT_NXT(a_fire_restarts, clock, reset, fire,
      elapsed_ff == 17'd0 && rsp_valid_ff)
   `MSSS_ASSERT_IMP(a_stall_cause, clock, reset, req_stall,
      s1_valid_ff && rsp_valid_ff && rsp_stall)

endmodule

[test/testbench.sv]
// Self-checking testbench for multiplexed_seven_segment_scanner_core.
// Predicts digit refresh results from the requests it sends and checks each one.
// Depends on msss_pkg and the scanner RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SLOT_TOTAL      = msss_pkg::NUM_DIGITS_DEFAULT;
   localparam int COLON_SLOT      = msss_pkg::COLON_POSITION_DEFAULT % SLOT_TOTAL;
   localparam int CATHODE_SLOT_LO = 2;
   localparam int CATHODE_SLOT_HI = 3;
   localparam logic [2:0] ACT_UNUSED_FIRST = 3'd5;
   localparam logic [2:0] ACT_UNUSED_LAST  = 3'd7;
   localparam int MAX_IDLE        = 4;
   localparam int SETTLE_CYCLES   = 4;
   localparam int DRAIN_LIMIT     = 2000;
   localparam int CYCLE_LIMIT     = 1_000_000;
   localparam int REPORT_LIMIT    = 10;
   localparam int RANDOM_PHASES   = 8;
   localparam int PHASE_REQUESTS  = 90;
   localparam int EXTREME_TICKS   = 64;

   localparam logic [7:0] DECIMAL_SEGMENTS [10] = '{
      8'h7E, 8'h18, 8'h37, 8'h3D, 8'h59, 8'h6D, 8'h6F, 8'h38, 8'h7F, 8'h7D
   };

   typedef struct packed {
      logic [2:0] index;
      logic       enable;
      logic       level;
      logic [6:0] segments;
   } refresh_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [2:0]  req_action = '0;
   logic [2:0]  req_digit_pos = '0;
   logic [7:0]  req_value = '0;
   logic        req_colon_off = 1'b0;
   logic        req_blink_phase = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_digit_index;
   logic        rsp_digit_enable;
   logic        rsp_digit_level;
   logic [6:0]  rsp_segment_levels;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_scan_interval = '0;

   logic [7:0]  code_shadow [SLOT_TOTAL];
   logic [2:0]  scan_slot;
   logic [16:0] elapsed_ticks;
   logic [15:0] interval_setting;
   refresh_type expected_refreshes [$];

   bit          idle_on = 1'b1;
   int          stall_left = 0;
   int          failures = 0;
   int          cycle_count = 0;
   int          drain_cycles;

   multiplexed_seven_segment_scanner_core u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_digit_pos      (req_digit_pos),
      .req_value          (req_value),
      .req_colon_off      (req_colon_off),
      .req_blink_phase    (req_blink_phase),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_digit_index    (rsp_digit_index),
      .rsp_digit_enable   (rsp_digit_enable),
      .rsp_digit_level    (rsp_digit_level),
      .rsp_segment_levels (rsp_segment_levels),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_scan_interval  (csr_scan_interval)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void apply_request(input logic [2:0] act, input logic [2:0] pos,
                                         input logic [7:0] val, input logic off,
                                         input logic phase);
      int          slot;
      logic [7:0]  code;
      refresh_type refresh;
      slot = pos % SLOT_TOTAL;
      unique case (act)
         msss_pkg::ACT_DECIMAL, msss_pkg::ACT_RAW: begin
            code = (act == msss_pkg::ACT_DECIMAL) ? DECIMAL_SEGMENTS[val % 10] : val;
            if (slot == CATHODE_SLOT_LO || slot == CATHODE_SLOT_HI) begin
               code = code | msss_pkg::CATHODE_BIT;
            end
            code_shadow[slot] = code;
         end
         msss_pkg::ACT_CLEAR: begin
            code_shadow[slot] = '0;
         end
         msss_pkg::ACT_COLON: begin
            code_shadow[COLON_SLOT] = (phase && !off)
                                      ? (msss_pkg::COLON_CODE | msss_pkg::CATHODE_BIT)
                                      : 8'h00;
         end
         msss_pkg::ACT_TICK: begin
            if (elapsed_ticks != msss_pkg::ELAPSED_MAX) begin
               elapsed_ticks++;
            end
            if (elapsed_ticks > {1'b0, interval_setting}) begin
               code = code_shadow[scan_slot];
               refresh = '0;
               refresh.index = scan_slot;
               if (code[6:0] != '0) begin
                  refresh.enable   = 1'b1;
                  refresh.level    = code[7];
                  refresh.segments = code[7] ? ~code[6:0] : code[6:0];
               end
               expected_refreshes.push_back(refresh);
               scan_slot = (scan_slot == 3'(SLOT_TOTAL - 1)) ? 3'd0 : scan_slot + 3'd1;
               elapsed_ticks = '0;
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void check_refresh();
      refresh_type actual;
      refresh_type expected;
      actual = '{rsp_digit_index, rsp_digit_enable, rsp_digit_level, rsp_segment_levels};
      if (expected_refreshes.size() == 0) begin
         failures++;
         if (failures <= REPORT_LIMIT) begin
            $display("Unexpected refresh: index %0d enable %0b level %0b segments %07b",
                     actual.index, actual.enable, actual.level, actual.segments);
         end
      end else begin
         expected = expected_refreshes.pop_front();
         if (actual.index !== expected.index || actual.enable !== expected.enable ||
             actual.level !== expected.level || actual.segments !== expected.segments) begin
            failures++;
            if (failures <= REPORT_LIMIT) begin
               $display("Refresh mismatch: expected %0d/%0b/%0b/%07b, got %0d/%0b/%0b/%07b",
                        expected.index, expected.enable, expected.level, expected.segments,
                        actual.index, actual.enable, actual.level, actual.segments);
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_refresh();
            stall_left = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic send_request(input logic [2:0] act, input logic [2:0] pos,
                               input logic [7:0] val, input logic off, input logic phase);
      int gap;
      gap = idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= act;
      req_digit_pos   <= pos;
      req_value       <= val;
      req_colon_off   <= off;
      req_blink_phase <= phase;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      apply_request(act, pos, val, off, phase);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_refreshes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_interval(input logic [15:0] setting);
      wait_idle();
      csr_valid         <= 1'b1;
      csr_scan_interval <= setting;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      interval_setting = setting;
   endtask

   task automatic send_ticks(input int count);
      repeat (count) send_request(msss_pkg::ACT_TICK, 3'($urandom), 8'($urandom),
                                  1'($urandom), 1'($urandom));
   endtask

   // The interval after reset must hold off the first refresh for 1000 ticks.
   task automatic test_reset_interval();
      send_request(msss_pkg::ACT_DECIMAL, 3'd0, 8'd8, 1'b0, 1'b0);
      send_ticks(int'(msss_pkg::SCAN_INTERVAL_RST) + 1);
      wait_idle();
   endtask

   task automatic test_special_codes();
      write_interval(16'd0);
      send_request(msss_pkg::ACT_DECIMAL, 3'd0, 8'd255, 1'b0, 1'b0);
      send_request(msss_pkg::ACT_DECIMAL, 3'd7, 8'd0, 1'b1, 1'b1);
      send_request(msss_pkg::ACT_RAW, 3'd2, 8'h01, 1'b0, 1'b0);
      send_request(msss_pkg::ACT_RAW, 3'd3, 8'h00, 1'b0, 1'b0);
      send_request(msss_pkg::ACT_COLON, 3'd0, 8'h00, 1'b0, 1'b1);
      send_request(msss_pkg::ACT_RAW, 3'd5, 8'hFF, 1'b1, 1'b1);
      for (int act = ACT_UNUSED_FIRST; act <= ACT_UNUSED_LAST; act++) begin
         send_request(3'(act), 3'($urandom), 8'($urandom), 1'($urandom), 1'($urandom));
      end
      send_ticks(SLOT_TOTAL);
      send_request(msss_pkg::ACT_CLEAR, 3'd6, 8'hFF, 1'b1, 1'b1);
      send_request(msss_pkg::ACT_COLON, 3'd7, 8'hFF, 1'b1, 1'b1);
      send_request(msss_pkg::ACT_RAW, 3'd7, 8'h80, 1'b0, 1'b0);
      send_request(msss_pkg::ACT_RAW, 3'd4, 8'h7F, 1'b0, 1'b0);
      send_request(msss_pkg::ACT_CLEAR, 3'd7, 8'h00, 1'b0, 1'b0);
      send_ticks(SLOT_TOTAL);
      send_request(msss_pkg::ACT_COLON, 3'd0, 8'h00, 1'b0, 1'b0);
      send_ticks(SLOT_TOTAL);
      wait_idle();
   endtask

   task automatic test_interval_extremes();
      idle_on = 1'b0;
      write_interval(16'hFFFF);
      send_request(msss_pkg::ACT_RAW, 3'($urandom_range(0, SLOT_TOTAL - 1)), 8'h2A,
                   1'b0, 1'b0);
      send_ticks(EXTREME_TICKS);
      idle_on = 1'b1;
      write_interval(16'd1);
      send_ticks(3 * SLOT_TOTAL);
      wait_idle();
   endtask

   task automatic run_random_phase(input int count);
      int         sent;
      int         pick;
      logic [2:0] act;
      logic [7:0] val;
      sent = 0;
      while (sent < count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            act = msss_pkg::ACT_TICK;
         end else if (pick < 60) begin
            act = msss_pkg::ACT_DECIMAL;
         end else if (pick < 75) begin
            act = msss_pkg::ACT_RAW;
         end else if (pick < 83) begin
            act = msss_pkg::ACT_CLEAR;
         end else if (pick < 93) begin
            act = msss_pkg::ACT_COLON;
         end else begin
            act = 3'($urandom_range(ACT_UNUSED_FIRST, ACT_UNUSED_LAST));
         end
         val = 8'($urandom);
         if (act == msss_pkg::ACT_RAW && $urandom_range(0, 7) == 0) begin
            val = val & msss_pkg::CATHODE_BIT;
         end
         send_request(act, 3'($urandom), val, 1'($urandom), 1'($urandom));
         if (act <= msss_pkg::ACT_COLON) begin
            sent++;
         end
      end
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         idle_on = (phase % 4) != 3;
         unique case (phase)
            0: write_interval(16'd0);
            1: write_interval(16'd1);
            2: write_interval(16'd2);
            3: write_interval(16'd0);
            default: write_interval(16'($urandom_range(0, 7)));
         endcase
         run_random_phase(PHASE_REQUESTS);
      end
      idle_on = 1'b1;
      wait_idle();
   endtask

   initial begin
      for (int i = 0; i < SLOT_TOTAL; i++) begin
         code_shadow[i] = '0;
      end
      scan_slot        = '0;
      elapsed_ticks    = '0;
      interval_setting = msss_pkg::SCAN_INTERVAL_RST;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_reset_interval();
      test_special_codes();
      test_interval_extremes();
      test_random_traffic();

      req_valid <= 1'b0;
      drain_cycles = 0;
      while (expected_refreshes.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      failures += expected_refreshes.size();
      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
